### rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types and codes for the gyro bias calibrator: the sample and result
// structures, the phase encoding, the status codes and the register indexes.
// ----------------------------------------------------------------------------
package gbc_pkg;

   localparam int AXIS_W = 16;
   localparam int REQ_W  = 48;
   localparam int RSP_W  = 56;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [1:0] STATUS_SETTLE = 2'd0;
   localparam logic [1:0] STATUS_SAMPLE = 2'd1;
   localparam logic [1:0] STATUS_DONE   = 2'd2;
   localparam logic [1:0] STATUS_ABORT  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTION_LIMIT = 8'd1;

   localparam logic [15:0] SETTLE_TICKS_RESET = 16'd600;
   localparam logic [31:0] MOTION_LIMIT_RESET = 32'd14400;

   typedef enum logic [3:0] {
      PH_SETTLE = 4'b0001,
      PH_SAMPLE = 4'b0010,
      PH_DONE   = 4'b0100,
      PH_ABORT  = 4'b1000
   } phase_type;

   // x sits in the lowest bits.
   typedef struct packed {
      logic signed [AXIS_W-1:0] z;
      logic signed [AXIS_W-1:0] y;
      logic signed [AXIS_W-1:0] x;
   } sample_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] offset_z;
      logic signed [AXIS_W-1:0] offset_y;
      logic signed [AXIS_W-1:0] offset_x;
      logic [1:0]               status;
   } result_type;

   typedef struct packed {
      logic                   write;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

endpackage

### rtl/gbc_div_const.sv
// ----------------------------------------------------------------------------
// gbc_div_const
// Signed division by a constant, truncating toward zero, done as a multiply
// by a rounded-up reciprocal on the magnitude. Exact for every input value.
// ----------------------------------------------------------------------------
module gbc_div_const #(
   parameter int DIVISOR = 400,
   parameter int IN_W    = 25
) (
   input  logic signed [IN_W-1:0]           dividend,
   output logic signed [gbc_pkg::AXIS_W-1:0] quotient
);

   localparam int LOGD   = $clog2(DIVISOR);
   localparam int SHIFT  = IN_W + LOGD;
   localparam int M_W    = IN_W + 1;
   localparam int PROD_W = IN_W + M_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

   logic                        negative;
   logic [IN_W-1:0]             magnitude;
   logic [PROD_W-1:0]           product;
   logic [gbc_pkg::AXIS_W-1:0]  q_mag;

   assign negative  = dividend[IN_W-1];
   assign magnitude = negative ? IN_W'(-dividend) : IN_W'(dividend);
   assign product   = PROD_W'(magnitude) * PROD_W'(RECIP);
   // The quotient magnitude never exceeds 32768, which still negates cleanly.
   assign q_mag     = product[SHIFT +: gbc_pkg::AXIS_W];
   assign quotient  = negative ? $signed(-q_mag) : $signed(q_mag);

endmodule

### rtl/gbc_core.sv
// ----------------------------------------------------------------------------
// gbc_core
// Calibration state and the per-tick step: settling count, motion check by
// squared distance, running sums and the final averaging.
// ----------------------------------------------------------------------------
module gbc_core #(
   parameter int SAMPLE_COUNT = 400
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  gbc_pkg::sample_type    sample,
   input  gbc_pkg::csr_write_type csr,
   output gbc_pkg::result_type    result
);

   localparam int SUM_W = gbc_pkg::AXIS_W + $clog2(SAMPLE_COUNT);
   localparam logic [15:0] COUNT_LIMIT = 16'(SAMPLE_COUNT);

   logic [15:0]                  settle_ticks_ff;
   logic [31:0]                  motion_limit_ff;
   gbc_pkg::phase_type           phase_ff, phase_in;
   logic [15:0]                  count_ff, count_in;
   logic                         seeded_ff, seeded_in;
   logic signed [15:0]           prev_ff [3];
   logic signed [15:0]           prev_in [3];
   logic signed [SUM_W-1:0]      sum_ff  [3];
   logic signed [SUM_W-1:0]      sum_in  [3];
   logic signed [15:0]           bias_ff [3];
   logic signed [15:0]           bias_in [3];
   logic signed [15:0]           quot    [3];
   logic signed [15:0]           s       [3];
   logic signed [15:0]           prev_eff [3];
   logic signed [16:0]           diff    [3];
   logic [31:0]                  square  [3];
   logic [33:0]                  dist_sq;
   logic                         enter_sample;
   logic                         sampling;
   logic [15:0]                  count_s;
   logic [1:0]                   status;

   assign s[0] = sample.x;
   assign s[1] = sample.y;
   assign s[2] = sample.z;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      gbc_div_const #(
         .DIVISOR (SAMPLE_COUNT),
         .IN_W    (SUM_W)
      ) u_div (
         .dividend (sum_ff[a]),
         .quotient (quot[a])
      );

      // The first sample seeds the reference, so its distance is zero.
      assign prev_eff[a] = seeded_ff ? prev_ff[a] : s[a];
      assign diff[a]     = 17'(prev_eff[a]) - 17'(s[a]);
      // The square of a 17-bit difference still fits in 32 bits.
      assign square[a]   = 32'($unsigned(34'(diff[a]) * 34'(diff[a])));
   end

   assign dist_sq = 34'(square[0]) + 34'(square[1]) + 34'(square[2]);

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      seeded_in    = seeded_ff;
      prev_in      = prev_ff;
      sum_in       = sum_ff;
      bias_in      = bias_ff;
      enter_sample = 1'b0;

      if (phase_ff == gbc_pkg::PH_SETTLE) begin
         if (count_ff < settle_ticks_ff) begin
            count_in = count_ff + 16'd1;
         end else begin
            enter_sample = 1'b1;
         end
      end

      sampling = (phase_ff == gbc_pkg::PH_SAMPLE) || enter_sample;
      count_s  = enter_sample ? 16'd0 : count_ff;

      if (sampling) begin
         count_in = count_s;
         phase_in = gbc_pkg::PH_SAMPLE;
         if (count_s < COUNT_LIMIT) begin
            seeded_in = 1'b1;
            if (dist_sq > 34'(motion_limit_ff)) begin
               phase_in = gbc_pkg::PH_ABORT;
               prev_in  = prev_eff;
            end else begin
               for (int a = 0; a < 3; a++) begin
                  prev_in[a] = s[a];
                  sum_in[a]  = sum_ff[a] + SUM_W'(s[a]);
               end
               count_in = count_s + 16'd1;
            end
         end else begin
            bias_in  = quot;
            phase_in = gbc_pkg::PH_DONE;
         end
      end
   end

   always_comb begin
      unique case (phase_in)
         gbc_pkg::PH_SETTLE: status = gbc_pkg::STATUS_SETTLE;
         gbc_pkg::PH_SAMPLE: status = gbc_pkg::STATUS_SAMPLE;
         gbc_pkg::PH_DONE:   status = gbc_pkg::STATUS_DONE;
         gbc_pkg::PH_ABORT:  status = gbc_pkg::STATUS_ABORT;
         default:            status = gbc_pkg::STATUS_ABORT;
      endcase
   end

   always_comb begin
      result.status = status;
      if (phase_in == gbc_pkg::PH_DONE) begin
         result.offset_x = bias_in[0];
         result.offset_y = bias_in[1];
         result.offset_z = bias_in[2];
      end else begin
         result.offset_x = '0;
         result.offset_y = '0;
         result.offset_z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff <= gbc_pkg::SETTLE_TICKS_RESET;
         motion_limit_ff <= gbc_pkg::MOTION_LIMIT_RESET;
      end else if (csr.write) begin
         unique case (csr.index)
            gbc_pkg::CSR_SETTLE_TICKS: settle_ticks_ff <= csr.data[15:0];
            gbc_pkg::CSR_MOTION_LIMIT: motion_limit_ff <= csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= gbc_pkg::PH_SETTLE;
         count_ff  <= '0;
         seeded_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= '0;
         end
      end else if (step_en) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         seeded_ff <= seeded_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         prev_ff <= prev_in;
         bias_ff <= bias_in;
      end
   end

endmodule

### rtl/gyro_bias_calibrator_unit.sv
// A request beat is taken into the input register and moves into the result register once
// that slot is free; rsp_tvalid is driven from the result register.
// Throughput: one request beat per cycle while the result stream is not stalled; the
// calibration step for a tick is one core pass between the input and result registers.
// Reset (synchronous, active high) returns the block to settling with zero
// sums and the register defaults; the configuration port is always ready.
// ----------------------------------------------------------------------------
// gyro_bias_calibrator_unit
// Top level: stream ports, input register, calibration core, result register.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator_unit #(
   parameter int SAMPLE_COUNT = 400
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // gyro_x [15:0], gyro_y [31:16], gyro_z [47:32]
   input  logic [gbc_pkg::REQ_W-1:0]         req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status [1:0], offset_x [17:2], offset_y [33:18], offset_z [49:34], zero pad
   output logic [gbc_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gbc_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic                   in_valid_ff;
   gbc_pkg::sample_type    in_data_ff;
   logic                   out_valid_ff;
   gbc_pkg::result_type    out_data_ff;
   gbc_pkg::result_type    core_result;
   gbc_pkg::csr_write_type csr;
   logic                   advance;

   // A buffered beat moves into the result register whenever that slot frees.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign csr.write = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   gbc_core #(
      .SAMPLE_COUNT (SAMPLE_COUNT)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .sample  (in_data_ff),
      .csr     (csr),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_data_ff};

endmodule

### rtl/gbc_checker.sv
// ----------------------------------------------------------------------------
// gbc_checker
// Port-level result stream checks: stall hold, idle after reset, zero offsets
// outside the calibrated state, and terminal calibrated and aborted states.
// ----------------------------------------------------------------------------
module gbc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [gbc_pkg::RSP_W-1:0]  rsp_tdata
);

   logic                       rsp_beat;
   logic                       done_seen_ff;
   logic                       abort_seen_ff;
   logic [gbc_pkg::RSP_W-1:0]  done_data_ff;

   assign rsp_beat = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_seen_ff  <= 1'b0;
         abort_seen_ff <= 1'b0;
      end else if (rsp_beat) begin
         if (rsp_tdata[1:0] == gbc_pkg::STATUS_DONE) begin
            done_seen_ff <= 1'b1;
         end
         if (rsp_tdata[1:0] == gbc_pkg::STATUS_ABORT) begin
            abort_seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_beat && !done_seen_ff) begin
         done_data_ff <= rsp_tdata;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_zero_offsets: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != gbc_pkg::STATUS_DONE |-> rsp_tdata[55:2] == '0)
      else $error("offsets not zero outside the calibrated state");

   a_done_held: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && done_seen_ff |-> rsp_tdata == done_data_ff)
      else $error("calibrated result changed after calibration");

   a_abort_held: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && abort_seen_ff |-> rsp_tdata[1:0] == gbc_pkg::STATUS_ABORT)
      else $error("left the aborted state without reset");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind gyro_bias_calibrator_unit gbc_checker u_gbc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### sim/gyro_bias_calibrator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gyro_bias_calibrator_unit_tb
// Self-checking bench for the gyro bias calibrator. Drives timer ticks with
// three-axis samples through settling, sampling and the held final state,
// rewrites the registers between phases, and compares every result beat with
// a cycle-free model of the calibration kept in a small scoreboard.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator_unit_tb;

   localparam int SAMPLES = 400;

   // Indexes that decode to no register; writes to them must change nothing.
   localparam logic [gbc_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 8'd2;
   localparam logic [gbc_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 8'hFF;

   localparam int AXIS_MIN = -32768;
   localparam int AXIS_MAX = 32767;

   class bias_scoreboard;
      int                  sample_total;
      logic [15:0]         settle_ticks;
      logic [31:0]         motion_limit;
      int unsigned         tick_count;
      bit                  seeded;
      logic [1:0]          phase;
      int                  prev_sample[3];
      int                  axis_sum[3];
      int                  bias[3];
      gbc_pkg::result_type expected_results[$];
      int                  errors;
      int                  compared;
      int                  ticks_taken;
      int                  samples_summed;

      function new(int samples);
         sample_total   = samples;
         settle_ticks   = gbc_pkg::SETTLE_TICKS_RESET;
         motion_limit   = gbc_pkg::MOTION_LIMIT_RESET;
         tick_count     = 0;
         seeded         = 1'b0;
         phase          = gbc_pkg::STATUS_SETTLE;
         errors         = 0;
         compared       = 0;
         ticks_taken    = 0;
         samples_summed = 0;
         foreach (prev_sample[k]) begin
            prev_sample[k] = 0;
            axis_sum[k]    = 0;
            bias[k]        = 0;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void take_write(logic [gbc_pkg::CSR_INDEX_W-1:0] index,
                               logic [gbc_pkg::CSR_DATA_W-1:0] data);
         if (index == gbc_pkg::CSR_SETTLE_TICKS) begin
            settle_ticks = data[15:0];
         end else if (index == gbc_pkg::CSR_MOTION_LIMIT) begin
            motion_limit = data;
         end
      endfunction

      // Advances the calibration by one tick and queues the beat it produces.
      function void take_tick(gbc_pkg::sample_type s);
         int                  axis_val[3];
         longint              dist_sq;
         longint              d;
         gbc_pkg::result_type r;
         axis_val[0] = $signed(s.x);
         axis_val[1] = $signed(s.y);
         axis_val[2] = $signed(s.z);
         ticks_taken++;
         // The tick that ends settling already takes the first sample.
         if (phase == gbc_pkg::STATUS_SETTLE) begin
            if (tick_count < settle_ticks) begin
               tick_count++;
            end else begin
               phase      = gbc_pkg::STATUS_SAMPLE;
               tick_count = 0;
            end
         end
         if (phase == gbc_pkg::STATUS_SAMPLE) begin
            if (tick_count < sample_total) begin
               if (!seeded) begin
                  foreach (axis_val[k]) prev_sample[k] = axis_val[k];
                  seeded = 1'b1;
               end
               dist_sq = 0;
               foreach (axis_val[k]) begin
                  d = prev_sample[k] - axis_val[k];
                  dist_sq += d * d;
               end
               if (dist_sq > longint'({32'd0, motion_limit})) begin
                  phase = gbc_pkg::STATUS_ABORT;
               end else begin
                  foreach (axis_val[k]) begin
                     prev_sample[k] = axis_val[k];
                     axis_sum[k]   += axis_val[k];
                  end
                  tick_count++;
                  samples_summed++;
               end
            end else begin
               // Integer division truncates toward zero, as the offsets must.
               foreach (bias[k]) bias[k] = axis_sum[k] / sample_total;
               phase = gbc_pkg::STATUS_DONE;
            end
         end
         r.status   = phase;
         r.offset_x = (phase == gbc_pkg::STATUS_DONE) ? 16'(bias[0]) : '0;
         r.offset_y = (phase == gbc_pkg::STATUS_DONE) ? 16'(bias[1]) : '0;
         r.offset_z = (phase == gbc_pkg::STATUS_DONE) ? 16'(bias[2]) : '0;
         expected_results.push_back(r);
      endfunction

      task report_mismatch(string what, int got, int want);
         errors++;
         if (errors <= 40) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
         end
      endtask

      task check_result(gbc_pkg::result_type got);
         gbc_pkg::result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result beat, status", got.status, 0);
            return;
         end
         want = expected_results.pop_front();
         compared++;
         if (got.status !== want.status) begin
            report_mismatch("status", got.status, want.status);
         end
         if (got.offset_x !== want.offset_x) begin
            report_mismatch("offset_x", $signed(got.offset_x), $signed(want.offset_x));
         end
         if (got.offset_y !== want.offset_y) begin
            report_mismatch("offset_y", $signed(got.offset_y), $signed(want.offset_y));
         end
         if (got.offset_z !== want.offset_z) begin
            report_mismatch("offset_z", $signed(got.offset_z), $signed(want.offset_z));
         end
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   // gyro_x [15:0], gyro_y [31:16], gyro_z [47:32]
   logic [gbc_pkg::REQ_W-1:0]       req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   // status [1:0], offset_x [17:2], offset_y [33:18], offset_z [49:34], zero pad
   logic [gbc_pkg::RSP_W-1:0]       rsp_tdata;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [gbc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [gbc_pkg::CSR_DATA_W-1:0]  csr_data;

   bias_scoreboard sb;
   bit             req_burst;
   bit             rsp_burst;

   gyro_bias_calibrator_unit #(
      .SAMPLE_COUNT(SAMPLES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The limit sits far above the slowest legal run of about 1200 ticks.
   initial begin : watchdog
      #(2_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic gbc_pkg::sample_type pack_sample(int x, int y, int z);
      gbc_pkg::sample_type s;
      s.x = 16'(x);
      s.y = 16'(y);
      s.z = 16'(z);
      return s;
   endfunction

   function automatic gbc_pkg::sample_type random_sample();
      return pack_sample($urandom, $urandom, $urandom);
   endfunction

   // Picks a value within radius of centre, clipped to the axis range.
   function automatic int axis_near(int centre, int radius);
      int lo;
      int hi;
      lo = centre - radius;
      hi = centre + radius;
      if (lo < AXIS_MIN) lo = AXIS_MIN;
      if (hi > AXIS_MAX) hi = AXIS_MAX;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Largest per-axis step that keeps the squared distance within the limit.
   function automatic int step_radius(logic [31:0] limit);
      int r;
      r = int'($sqrt(real'(limit) / 3.0)) + 1;
      if (r > 65535) r = 65535;
      while (r > 0 && longint'(3) * r * r > longint'({32'd0, limit})) r--;
      return r;
   endfunction

   task automatic send_tick(gbc_pkg::sample_type s);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.take_tick(s);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [gbc_pkg::CSR_INDEX_W-1:0] index,
                            logic [gbc_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.take_write(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Holds off new ticks until every queued result has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic pick_pacing();
      req_burst = ($urandom_range(0, 2) == 0);
      rsp_burst = ($urandom_range(0, 2) == 0);
   endtask

   initial begin : rsp_side
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata[$bits(gbc_pkg::result_type)-1:0]);
      end
   end

   initial begin : stimulus
      int                  seg;
      int                  n;
      int                  i;
      int                  r;
      int                  abort_at;
      int                  jump_x;
      bit                  abort_run;
      logic [31:0]         limit;
      gbc_pkg::sample_type s;

      sb         = new(SAMPLES);
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_burst  = 1'b0;
      rsp_burst  = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Settling under the reset defaults: extremes and alternating bit patterns.
      send_tick(pack_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN));
      send_tick(pack_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX));
      send_tick(pack_sample(0, 0, 0));
      send_tick(pack_sample(-1, -1, -1));
      send_tick(pack_sample(21845, -21846, 21845));
      send_tick(pack_sample(-21846, 21845, -21846));

      wait_idle();
      write_reg(gbc_pkg::CSR_SETTLE_TICKS, 32'h0000_FFFF);
      write_reg(gbc_pkg::CSR_MOTION_LIMIT, 32'd0);
      write_reg(CSR_SPARE_LOW, $urandom);
      write_reg(CSR_SPARE_HIGH, $urandom);

      // Long settling: the samples are ignored, so any content will do.
      for (i = 0; i < 5; i++) begin
         pick_pacing();
         repeat (50) send_tick(random_sample());
      end

      // Dropping the count below what was reached ends settling on the next tick.
      wait_idle();
      write_reg(gbc_pkg::CSR_SETTLE_TICKS, 32'd0);

      // With a zero limit only a repeat of the seed sample is still.
      send_tick(pack_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN));
      send_tick(pack_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN));
      send_tick(pack_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN));
      send_tick(pack_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN));

      // A full swing on one axis just fits under the widest limit.
      wait_idle();
      write_reg(gbc_pkg::CSR_MOTION_LIMIT, 32'hFFFF_FFFF);
      send_tick(pack_sample(AXIS_MAX, AXIS_MIN, AXIS_MIN));
      send_tick(pack_sample(AXIS_MAX, AXIS_MAX, AXIS_MIN));
      send_tick(pack_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX));

      // Two steps whose squared distance equals the default limit exactly, then a repeat.
      wait_idle();
      write_reg(gbc_pkg::CSR_MOTION_LIMIT, gbc_pkg::MOTION_LIMIT_RESET);
      send_tick(pack_sample(AXIS_MAX - 120, AXIS_MAX, AXIS_MAX));
      send_tick(pack_sample(AXIS_MAX - 192, AXIS_MAX - 96, AXIS_MAX));
      send_tick(pack_sample(AXIS_MAX - 192, AXIS_MAX - 96, AXIS_MAX));

      // Random walks that stay within the limit; now and then the last segment
      // holds a jump that aborts the calibration.
      abort_run = ($urandom_range(0, 3) == 0);
      for (seg = 0; seg < 3; seg++) begin
         wait_idle();
         case (seg)
            0: limit = gbc_pkg::MOTION_LIMIT_RESET;
            1: limit = $urandom;
            default: limit = $urandom_range(3000, 20000);
         endcase
         write_reg(gbc_pkg::CSR_MOTION_LIMIT, limit);
         if (seg == 1) write_reg(CSR_SPARE_LOW, $urandom);
         pick_pacing();
         r = step_radius(limit);
         n = (seg < 2) ? 130 : SAMPLES - int'(sb.tick_count);
         abort_at = (n > 0) ? $urandom_range(0, n - 1) : 0;
         for (i = 0; i < n; i++) begin
            if (abort_run && seg == 2 && i == abort_at) begin
               // 200 squared is beyond any limit used in this segment.
               jump_x = (sb.prev_sample[0] >= 0) ? sb.prev_sample[0] - 200 :
                                                   sb.prev_sample[0] + 200;
               s = pack_sample(jump_x, sb.prev_sample[1], sb.prev_sample[2]);
            end else begin
               s = pack_sample(axis_near(sb.prev_sample[0], r),
                               axis_near(sb.prev_sample[1], r),
                               axis_near(sb.prev_sample[2], r));
            end
            send_tick(s);
         end
      end

      // The final state holds whatever the registers and samples do.
      for (seg = 0; seg < 3; seg++) begin
         wait_idle();
         case (seg)
            0: write_reg(gbc_pkg::CSR_SETTLE_TICKS, $urandom);
            1: write_reg(gbc_pkg::CSR_MOTION_LIMIT, $urandom);
            default: write_reg(CSR_SPARE_HIGH, $urandom);
         endcase
         pick_pacing();
         repeat (180) send_tick(random_sample());
      end

      wait_idle();
      repeat (8) @(negedge clock);
      $display("Drove %0d ticks, %0d of them summed as still samples; %0d result beats compared.",
               sb.ticks_taken, sb.samples_summed, sb.compared);
      $display("Calibration ended in status %0d with offsets %0d, %0d, %0d.",
               sb.phase, sb.bias[0], sb.bias[1], sb.bias[2]);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/gbc_pkg.sv
rtl/gbc_div_const.sv
rtl/gbc_core.sv
rtl/gyro_bias_calibrator_unit.sv
rtl/gbc_checker.sv
sim/gyro_bias_calibrator_unit_tb.sv
